// File: rtl/core/vat_pkg.sv
// types and constants shared by the vertex affine transform
`timescale 1ns / 1ps
`default_nettype none

package vat_pkg;

  localparam int unsigned CoefW    = 16;
  localparam int unsigned CoefFrac = 14;
  localparam int unsigned CrdW     = 32;
  localparam int unsigned RowW     = 48;
  localparam int unsigned PrdW     = 48;
  localparam int unsigned MagW     = 50;
  localparam int unsigned PosW     = 52;
  localparam int unsigned NrmW     = 30;
  localparam int unsigned SqW      = 60;
  localparam int unsigned SumW     = 62;
  localparam int unsigned RootW    = 63;
  localparam int unsigned TmpW     = 64;
  localparam int unsigned QuoW     = 17;
  localparam int unsigned UnitFrac = 16;
  localparam int unsigned ShW      = 6;
  localparam int unsigned AddrW    = 6;
  localparam int unsigned DataW    = 64;
  localparam int unsigned RegSel   = 3;

  localparam int RndHalf = 8192;

  localparam logic [CrdW-1:0] MaxS = 32'h7fff_ffff;
  localparam logic [CrdW-1:0] MinS = 32'h8000_0000;

  localparam logic [RowW-1:0] Row0Rst = 48'h0000_0000_4000;
  localparam logic [RowW-1:0] Row1Rst = 48'h0000_4000_0000;
  localparam logic [RowW-1:0] Row2Rst = 48'h4000_0000_0000;

  // back pipeline stage map
  localparam int unsigned StgShamt  = 1;
  localparam int unsigned StgShift  = 2;
  localparam int unsigned StgSq     = 3;
  localparam int unsigned StgSum    = 4;
  localparam int unsigned StgRoot0  = 5;
  localparam int unsigned RootSteps = 32;
  localparam int unsigned StgDivSet = StgRoot0 + RootSteps;
  localparam int unsigned StgDiv0   = StgDivSet + 1;
  localparam int unsigned StgFin    = StgDiv0 + QuoW;
  localparam int unsigned NStg      = StgFin + 1;

  typedef enum logic [2:0] {
    REG_ROW0 = 3'd0,
    REG_ROW1 = 3'd1,
    REG_ROW2 = 3'd2,
    REG_TX   = 3'd3,
    REG_TY   = 3'd4,
    REG_TZ   = 3'd5
  } reg_idx_e;

  typedef enum logic {
    KIND_POS = 1'b0,
    KIND_DIR = 1'b1
  } kind_e;

  typedef struct packed {
    logic [2:0][RowW-1:0] row;
    logic [2:0][CrdW-1:0] tr;
  } cfg_t;

  typedef struct packed {
    logic                 full;
    logic                 empty;
  } qst_t;

  typedef struct packed {
    logic                 dir;
    logic                 sat;
    logic [2:0]           neg;
    logic [2:0][MagW-1:0] val;
  } ent_t;

  typedef struct packed {
    logic                 dir;
    logic                 sat;
    logic                 zero;
    logic [2:0]           neg;
    logic [2:0][MagW-1:0] val;
    logic                 shr;
    logic [ShW-1:0]       sh;
    logic [2:0][SqW-1:0]  sq;
    logic [SumW-1:0]      n;
    logic [RootW-1:0]     r;
    logic [2:0][QuoW-1:0] q;
  } bk_t;

endpackage

`default_nettype wire

// File: rtl/core/vat_if.sv
// vertex and result channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface vat_in_if import vat_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic                   kind;
  logic signed [CrdW-1:0] in_x;
  logic signed [CrdW-1:0] in_y;
  logic signed [CrdW-1:0] in_z;

  modport source (output valid, kind, in_x, in_y, in_z, input ready);
  modport sink (input valid, kind, in_x, in_y, in_z, output ready);
endinterface

interface vat_out_if import vat_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic signed [CrdW-1:0] out_x;
  logic signed [CrdW-1:0] out_y;
  logic signed [CrdW-1:0] out_z;
  logic                   saturated;

  modport source (output valid, out_x, out_y, out_z, saturated, input ready);
  modport sink (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface

`default_nettype wire

// File: rtl/core/vat_regs.sv
// apb configuration registers
`timescale 1ns / 1ps
`default_nettype none

module vat_regs import vat_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;

  assign idx    = reg_idx_e'(paddr[AddrW-1:RegSel]);
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row[0] <= Row0Rst;
      cfg_q.row[1] <= Row1Rst;
      cfg_q.row[2] <= Row2Rst;
      cfg_q.tr     <= '0;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_ROW0: cfg_q.row[0] <= pwdata[RowW-1:0];
        REG_ROW1: cfg_q.row[1] <= pwdata[RowW-1:0];
        REG_ROW2: cfg_q.row[2] <= pwdata[RowW-1:0];
        REG_TX:   cfg_q.tr[0]  <= pwdata[CrdW-1:0];
        REG_TY:   cfg_q.tr[1]  <= pwdata[CrdW-1:0];
        REG_TZ:   cfg_q.tr[2]  <= pwdata[CrdW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ROW0: prdata = DataW'(cfg_q.row[0]);
      REG_ROW1: prdata = DataW'(cfg_q.row[1]);
      REG_ROW2: prdata = DataW'(cfg_q.row[2]);
      REG_TX:   prdata = DataW'(cfg_q.tr[0]);
      REG_TY:   prdata = DataW'(cfg_q.tr[1]);
      REG_TZ:   prdata = DataW'(cfg_q.tr[2]);
      default:  prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/vat_front.sv
// front end: vertex intake, matrix products, translation and magnitude split
`timescale 1ns / 1ps
`default_nettype none

module vat_front import vat_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  vat_in_if.sink vtx_i,
  input  cfg_t   cfg_i,
  input  qst_t   qst_i,
  output logic   push_o,
  output ent_t   ent_o
);

  logic                   f1_vld_q;
  logic                   f2_vld_q;
  logic                   f1_dir_q;
  logic                   adv;
  logic signed [PrdW-1:0] prd_d [3][3];
  logic signed [PrdW-1:0] prd_q [3][3];
  ent_t                   ent_d;
  ent_t                   ent_q;

  assign adv         = !f2_vld_q || !qst_i.full;
  assign vtx_i.ready = adv;
  assign push_o      = f2_vld_q && !qst_i.full;
  assign ent_o       = ent_q;

  // nine coefficient products
  always_comb begin : mul
    logic signed [CrdW-1:0] xs [3];
    xs[0] = vtx_i.in_x;
    xs[1] = vtx_i.in_y;
    xs[2] = vtx_i.in_z;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prd_d[r][c] = $signed(cfg_i.row[r][c*CoefW +: CoefW]) * xs[c];
      end
    end
  end

  // row sums, translation, rounding and clamp or sign and magnitude
  always_comb begin : sum
    logic signed [MagW-1:0] acc;
    logic signed [PosW-1:0] a;
    logic signed [PosW-1:0] rs;
    logic [CrdW-1:0]        res;
    ent_d     = '0;
    ent_d.dir = f1_dir_q;
    for (int i = 0; i < 3; i++) begin
      acc = MagW'(prd_q[i][0]) + MagW'(prd_q[i][1]) + MagW'(prd_q[i][2]);
      a   = PosW'(acc) + (PosW'($signed(cfg_i.tr[i])) <<< CoefFrac) + PosW'(RndHalf);
      rs  = a >>> CoefFrac;
      if (rs[PosW-1:CrdW-1] == '0 || rs[PosW-1:CrdW-1] == '1) begin
        res = rs[CrdW-1:0];
      end else begin
        res = rs[PosW-1] ? MinS : MaxS;
        if (!f1_dir_q) begin
          ent_d.sat = 1'b1;
        end
      end
      if (f1_dir_q) begin
        ent_d.neg[i] = acc[MagW-1];
        ent_d.val[i] = acc[MagW-1] ? MagW'(-acc) : MagW'(acc);
      end else begin
        ent_d.val[i] = MagW'(res);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
      f2_vld_q <= 1'b0;
    end else if (adv) begin
      f1_vld_q <= vtx_i.valid;
      f2_vld_q <= f1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f1_dir_q <= (vtx_i.kind == KIND_DIR);
      prd_q    <= prd_d;
      ent_q    <= ent_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/vat_queue.sv
// short queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module vat_queue import vat_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  ent_t ent_i,
  input  logic pop_i,
  output ent_t head_o,
  output qst_t qst_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ent_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q;
  logic [PtrW-1:0] rd_q;
  logic [CntW-1:0] cnt_q;

  assign head_o      = mem_q[rd_q];
  assign qst_o.full  = (cnt_q == CntW'(Depth));
  assign qst_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + CntW'(push_i) - CntW'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= ent_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/vat_back.sv
// back end: direction normalize, square root and divide pipeline
`timescale 1ns / 1ps
`default_nettype none

module vat_back import vat_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ent_t       head_i,
  input  qst_t       qst_i,
  output logic       pop_o,
  vat_out_if.source  res_o
);

  function automatic bk_t f_load(input ent_t e);
    bk_t             s;
    logic [MagW-1:0] m;
    s     = '0;
    s.dir = e.dir;
    s.sat = e.sat;
    s.neg = e.neg;
    s.val = e.val;
    m = (e.val[0] > e.val[1]) ? e.val[0] : e.val[1];
    if (e.val[2] > m) begin
      m = e.val[2];
    end
    s.n    = SumW'(m);
    s.zero = (m == '0);
    return s;
  endfunction

  function automatic bk_t f_shamt(input bk_t s_i);
    bk_t            s;
    logic [ShW-1:0] msb;
    s   = s_i;
    msb = '0;
    for (int i = 0; i < MagW; i++) begin
      if (s.n[i]) begin
        msb = ShW'(i);
      end
    end
    s.shr = (s.n[MagW-1:NrmW] != '0);
    s.sh  = s.shr ? msb - ShW'(NrmW - 1) : ShW'(NrmW - 1) - msb;
    return s;
  endfunction

  function automatic bk_t f_shift(input bk_t s_i);
    bk_t s;
    s = s_i;
    if (s.dir && !s.zero) begin
      for (int i = 0; i < 3; i++) begin
        s.val[i] = s.shr ? (s.val[i] >> s.sh) : (s.val[i] << s.sh);
      end
    end
    return s;
  endfunction

  function automatic bk_t f_sq(input bk_t s_i);
    bk_t             s;
    logic [NrmW-1:0] a;
    s = s_i;
    for (int i = 0; i < 3; i++) begin
      a       = s.val[i][NrmW-1:0];
      s.sq[i] = a * a;
    end
    return s;
  endfunction

  function automatic bk_t f_sum(input bk_t s_i);
    bk_t s;
    s   = s_i;
    s.n = SumW'(s.sq[0]) + SumW'(s.sq[1]) + SumW'(s.sq[2]);
    s.r = '0;
    return s;
  endfunction

  // one result bit of the integer square root
  function automatic bk_t f_root(input bk_t s_i, input int unsigned j);
    bk_t             s;
    logic [TmpW-1:0] bit_v;
    logic [TmpW-1:0] t;
    s     = s_i;
    bit_v = TmpW'(1) << (SumW - 2 * j);
    t     = TmpW'(s.r) + bit_v;
    if (TmpW'(s.n) >= t) begin
      s.n = s.n - SumW'(t);
      s.r = RootW'((TmpW'(s.r) >> 1) + bit_v);
    end else begin
      s.r = s.r >> 1;
    end
    return s;
  endfunction

  function automatic bk_t f_dset(input bk_t s_i);
    bk_t s;
    s = s_i;
    if (s.dir && !s.zero) begin
      for (int i = 0; i < 3; i++) begin
        s.val[i] = (s.val[i] << UnitFrac) + MagW'(s.r >> 1);
      end
    end
    s.q = '0;
    return s;
  endfunction

  // one quotient bit in all three lanes
  function automatic bk_t f_div(input bk_t s_i, input int unsigned b);
    bk_t             s;
    logic [MagW-1:0] d;
    s = s_i;
    d = MagW'(s.r) << b;
    if (s.dir && !s.zero) begin
      for (int i = 0; i < 3; i++) begin
        if (s.val[i] >= d) begin
          s.val[i]  = s.val[i] - d;
          s.q[i][b] = 1'b1;
        end
      end
    end
    return s;
  endfunction

  function automatic bk_t f_fin(input bk_t s_i);
    bk_t             s;
    logic [CrdW-1:0] qx;
    logic [CrdW-1:0] v32;
    s = s_i;
    if (s.dir) begin
      for (int i = 0; i < 3; i++) begin
        qx  = CrdW'(s.q[i]);
        v32 = s.neg[i] ? (~qx + CrdW'(1)) : qx;
        if (s.zero) begin
          v32 = '0;
        end
        s.val[i] = MagW'(v32);
      end
    end
    return s;
  endfunction

  bk_t             stg_q [NStg];
  logic [NStg-1:0] vld_q;
  logic            adv;

  assign adv   = !vld_q[NStg-1] || res_o.ready;
  assign pop_o = adv && !qst_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NStg-2:0], pop_o};
    end
  end

  for (genvar k = 0; k < NStg; k++) begin : g_stg
    bk_t stg_d;
    if (k == 0) begin : g_load
      assign stg_d = f_load(head_i);
    end else if (k == StgShamt) begin : g_shamt
      assign stg_d = f_shamt(stg_q[k-1]);
    end else if (k == StgShift) begin : g_shift
      assign stg_d = f_shift(stg_q[k-1]);
    end else if (k == StgSq) begin : g_sq
      assign stg_d = f_sq(stg_q[k-1]);
    end else if (k == StgSum) begin : g_sum
      assign stg_d = f_sum(stg_q[k-1]);
    end else if (k < StgDivSet) begin : g_root
      assign stg_d = f_root(stg_q[k-1], k - StgRoot0);
    end else if (k == StgDivSet) begin : g_dset
      assign stg_d = f_dset(stg_q[k-1]);
    end else if (k < StgFin) begin : g_div
      assign stg_d = f_div(stg_q[k-1], QuoW - 1 - (k - StgDiv0));
    end else begin : g_fin
      assign stg_d = f_fin(stg_q[k-1]);
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        stg_q[k] <= stg_d;
      end
    end
  end

  assign res_o.valid     = vld_q[NStg-1];
  assign res_o.out_x     = stg_q[NStg-1].val[0][CrdW-1:0];
  assign res_o.out_y     = stg_q[NStg-1].val[1][CrdW-1:0];
  assign res_o.out_z     = stg_q[NStg-1].val[2][CrdW-1:0];
  assign res_o.saturated = stg_q[NStg-1].sat;

endmodule

`default_nettype wire

// File: rtl/core/vertex_affine_transform.sv
// top level of the vertex affine transform
`timescale 1ns / 1ps
`default_nettype none

// Transforms one vertex per clock by the 3x3 Q2.14 matrix in the row registers.
// Positions add the Q16.16 translation and saturate; directions are scaled to
// unit length. One item enters and one result leaves every clock while the
// result side is ready. A 32-step square root pipe and a 17-step divider in
// the 56 back stages renormalize directions. Registers sit at byte address
// 8*index on the 64-bit apb port; the user must write them only while the
// block is idle, which the block itself does not enforce.
module vertex_affine_transform import vat_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  vat_in_if.sink           vtx_i,
  vat_out_if.source        res_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  cfg_t cfg;
  qst_t qst;
  ent_t ent;
  ent_t head;
  logic push;
  logic pop;

  vat_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  vat_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vtx_i  (vtx_i),
    .cfg_i  (cfg),
    .qst_i  (qst),
    .push_o (push),
    .ent_o  (ent)
  );

  vat_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .ent_i  (ent),
    .pop_i  (pop),
    .head_o (head),
    .qst_o  (qst)
  );

  vat_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .qst_i  (qst),
    .pop_o  (pop),
    .res_o  (res_o)
  );

  a_queue_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(qst.full && qst.empty))
    else $error("queue full and empty at once");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vtx_i.ready |-> qst.full)
    else $error("intake stalled with room in queue");

  a_sat_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.saturated |->
      (res_o.out_x == MaxS || res_o.out_x == MinS ||
       res_o.out_y == MaxS || res_o.out_y == MinS ||
       res_o.out_z == MaxS || res_o.out_z == MinS))
    else $error("saturated flag without clamped component");

endmodule

`default_nettype wire

// File: bench/vertex_affine_transform_tb.sv
// testbench for the vertex affine transform: directed table, saturation extremes, then random vertices
`timescale 1ns / 1ps
`default_nettype none

module vertex_affine_transform_tb;
  import vat_pkg::*;

  typedef struct {
    logic        kind;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
    logic        known;
    logic [31:0] ex;
    logic [31:0] ey;
    logic [31:0] ez;
    logic        esat;
  } vec_row_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        sat;
  } vec_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic pready;

  vat_in_if  vtx_if ();
  vat_out_if res_if ();

  vertex_affine_transform u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vtx_i   (vtx_if.sink),
    .res_o   (res_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk_i = ~clk_i;

  logic [RowW-1:0] row_q [3];
  logic [31:0]     tr_q [3];
  vec_res_t        pending_q [$];
  int              err_cnt = 0;
  int              idle_cnt = 0;
  int              send_idle = 0;
  int              sink_stall = 0;
  logic            done = 1'b0;

  initial begin
    vtx_if.valid = 1'b0;
    vtx_if.kind = 1'b0;
    vtx_if.in_x = '0;
    vtx_if.in_y = '0;
    vtx_if.in_z = '0;
    res_if.ready = 1'b0;
  end

  function automatic longint signed coef_of(int r, int c);
    logic signed [15:0] k;
    k = row_q[r][16*c +: 16];
    return longint'(k);
  endfunction

  function automatic logic [63:0] isqrt(logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic vec_res_t transform_vertex(logic kind, logic [31:0] vx,
                                                logic [31:0] vy, logic [31:0] vz);
    longint signed v [3];
    longint signed acc [3];
    longint signed a;
    longint signed r;
    logic [63:0] mag [3];
    logic [63:0] m;
    logic [63:0] sq;
    logic [63:0] len;
    logic [63:0] q;
    logic        ng [3];
    logic [31:0] o [3];
    vec_res_t    res;
    v[0] = longint'($signed(vx));
    v[1] = longint'($signed(vy));
    v[2] = longint'($signed(vz));
    res.sat = 1'b0;
    for (int i = 0; i < 3; i++)
      acc[i] = coef_of(i, 0) * v[0] + coef_of(i, 1) * v[1] + coef_of(i, 2) * v[2];
    if (kind == KIND_POS) begin
      for (int i = 0; i < 3; i++) begin
        a = acc[i] + longint'($signed(tr_q[i])) * 16384 + RndHalf;
        r = a >>> 14;
        if (r > 64'sd2147483647) begin
          r = 64'sd2147483647;
          res.sat = 1'b1;
        end
        if (r < -64'sd2147483648) begin
          r = -64'sd2147483648;
          res.sat = 1'b1;
        end
        o[i] = r[31:0];
      end
    end else begin
      m = 0;
      for (int i = 0; i < 3; i++) begin
        ng[i] = acc[i] < 0;
        mag[i] = ng[i] ? 64'(-acc[i]) : 64'(acc[i]);
        if (mag[i] > m) m = mag[i];
      end
      if (m == 0) begin
        for (int i = 0; i < 3; i++) o[i] = '0;
      end else begin
        while (m >= (64'd1 << 30)) begin
          m = m >> 1;
          for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
        end
        while (m < (64'd1 << 29)) begin
          m = m << 1;
          for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
        end
        sq = 0;
        for (int i = 0; i < 3; i++) sq = sq + mag[i] * mag[i];
        len = isqrt(sq);
        for (int i = 0; i < 3; i++) begin
          q = ((mag[i] << 16) + (len >> 1)) / len;
          o[i] = ng[i] ? 32'(-q) : q[31:0];
        end
      end
    end
    res.x = o[0];
    res.y = o[1];
    res.z = o[2];
    return res;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  task automatic write_reg(reg_idx_e idx, logic [63:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= AddrW'(8 * int'(idx));
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx < REG_TX) row_q[idx] = val[RowW-1:0];
    else tr_q[idx - REG_TX] = val[31:0];
  endtask

  task automatic drain;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (NStg + 8) @(negedge clk_i);
  endtask

  task automatic send_vertex(logic kind, logic [31:0] vx, logic [31:0] vy,
                             logic [31:0] vz);
    while (send_idle != 0 && $urandom_range(99) < send_idle) begin
      vtx_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    vtx_if.valid <= 1'b1;
    vtx_if.kind <= kind;
    vtx_if.in_x <= vx;
    vtx_if.in_y <= vy;
    vtx_if.in_z <= vz;
    @(posedge clk_i);
    while (!vtx_if.ready) @(posedge clk_i);
    pending_q.insert(pending_q.size(), transform_vertex(kind, vx, vy, vz));
    @(negedge clk_i);
  endtask

  task automatic send_idle_low;
    vtx_if.valid <= 1'b0;
  endtask

  always @(negedge clk_i)
    if (rst_ni) res_if.ready <= !(sink_stall != 0 && $urandom_range(99) < sink_stall);

  always @(posedge clk_i) begin
    vec_res_t w;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_q.size() == 0) begin
        $display("unexpected result transfer at %0t", $realtime);
        err_cnt++;
      end else begin
        w = pending_q.pop_front();
        if (res_if.out_x !== w.x) report("out_x", res_if.out_x, w.x);
        if (res_if.out_y !== w.y) report("out_y", res_if.out_y, w.y);
        if (res_if.out_z !== w.z) report("out_z", res_if.out_z, w.z);
        if (res_if.saturated !== w.sat)
          report("saturated", 32'(res_if.saturated), 32'(w.sat));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((vtx_if.valid && vtx_if.ready) || (res_if.valid && res_if.ready) || done)
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt > 20000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [31:0] rnd_crd();
    case ($urandom_range(5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rnd_coef();
    case ($urandom_range(4))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom_range(32768)) - 16'd16384;
      default: return 16'($urandom);
    endcase
  endfunction

  // identity matrix after reset, so the position rows read straight off the input
  vec_row_t dir_tab [9] = '{
    '{KIND_POS, 32'h0001_0000, 32'h0002_0000, 32'hfffd_0000, 1, 32'h0001_0000,
      32'h0002_0000, 32'hfffd_0000, 0},
    '{KIND_POS, 32'h7fff_ffff, 32'h8000_0000, 32'h0, 1, 32'h7fff_ffff,
      32'h8000_0000, 32'h0, 0},
    '{KIND_DIR, 32'h0, 32'h0, 32'h0, 1, 32'h0, 32'h0, 32'h0, 0},
    '{KIND_DIR, 32'h0003_0000, 32'h0, 32'h0, 1, 32'h0001_0000, 32'h0, 32'h0, 0},
    '{KIND_DIR, 32'h0, 32'h8000_0000, 32'h0, 1, 32'h0, 32'hffff_0000, 32'h0, 0},
    '{KIND_DIR, 32'h0, 32'h0, 32'h0000_0001, 1, 32'h0, 32'h0, 32'h0001_0000, 0},
    '{KIND_DIR, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 0, 0},
    '{KIND_DIR, 32'h0000_0003, 32'h0000_0004, 32'h0, 0, 0, 0, 0, 0},
    '{KIND_POS, 32'hffff_ffff, 32'h0, 32'h1, 1, 32'hffff_ffff, 32'h0, 32'h1, 0}
  };

  initial begin
    vec_res_t p;
    row_q[0] = Row0Rst;
    row_q[1] = Row1Rst;
    row_q[2] = Row2Rst;
    for (int i = 0; i < 3; i++) tr_q[i] = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].known) begin
        p = transform_vertex(dir_tab[i].kind, dir_tab[i].vx, dir_tab[i].vy,
                             dir_tab[i].vz);
        if (p.x !== dir_tab[i].ex || p.y !== dir_tab[i].ey || p.z !== dir_tab[i].ez
            || p.sat !== dir_tab[i].esat) begin
          $display("table row %0d disagrees with predictor", i);
          err_cnt++;
        end
      end
      send_vertex(dir_tab[i].kind, dir_tab[i].vx, dir_tab[i].vy, dir_tab[i].vz);
    end
    send_idle_low();
    drain();

    // saturation extremes: full-scale coefficients and translation
    write_reg(REG_ROW0, {16'h7fff, 16'h7fff, 16'h7fff});
    write_reg(REG_ROW1, {16'h8000, 16'h8000, 16'h8000});
    write_reg(REG_ROW2, 48'h0);
    write_reg(REG_TX, 64'h7fff_ffff);
    write_reg(REG_TY, 64'h8000_0000);
    write_reg(REG_TZ, 64'h8000_0000);
    send_vertex(KIND_POS, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_vertex(KIND_POS, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vertex(KIND_DIR, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_vertex(KIND_POS, 32'h0, 32'h0, 32'h0);
    send_idle_low();
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  sink_stall = 0;  end
        1: begin send_idle = 74; sink_stall = 0;  end
        2: begin send_idle = 0;  sink_stall = 74; end
        default: begin send_idle = 20; sink_stall = 20; end
      endcase
      if (ph != 0) begin
        for (int r = 0; r < 3; r++)
          write_reg(reg_idx_e'(r), {rnd_coef(), rnd_coef(), rnd_coef()});
        for (int t = 0; t < 3; t++)
          write_reg(reg_idx_e'(REG_TX + t), {32'h0, rnd_crd()});
      end
      for (int n = 0; n < 250; n++)
        send_vertex(logic'($urandom_range(1)), rnd_crd(), rnd_crd(), rnd_crd());
      send_idle_low();
      drain();
    end

    done = 1'b1;
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
